@@ rtl/assert_macros.svh @@
// Assertion helpers used by the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// The consequent must hold once the delay dly has passed after the antecedent.
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("assertion failed: delayed consequence does not hold");

`endif

@@ rtl/jdcd_pkg.sv @@
`timescale 1ns / 1ps

package jdcd_pkg;

  // Width of the day number port.
  localparam int unsigned DAY_NUMBER_BITS = 39;
  localparam int unsigned YEAR_BITS = 31;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned LATENCY = 10;

  typedef logic [DAY_NUMBER_BITS-1:0] day_t;
  typedef logic [YEAR_BITS-1:0] year_t;

  localparam day_t AD_EPOCH = day_t'(1721424);
  localparam day_t LAST_JULIAN = day_t'(2299160);
  localparam day_t GREG_MARCH_EPOCH = day_t'(1721120);

  // Division by the 400-year Gregorian cycle. The reciprocal is truncated at
  // 2^DAY_NUMBER_BITS, so the estimated quotient is low by at most one.
  localparam int unsigned ERA_BITS = DAY_NUMBER_BITS - 17;
  localparam int unsigned ZLO_BITS = 24;
  localparam int unsigned ZHI_BITS = DAY_NUMBER_BITS - ZLO_BITS;
  typedef logic [ERA_BITS-1:0] era_t;
  typedef logic [DAY_NUMBER_BITS+ERA_BITS-1:0] era_prod_t;
  typedef logic [ERA_BITS+8:0] era400_t;
  localparam era_t ERA_RECIP = era_t'((64'd1 << DAY_NUMBER_BITS) / 64'd146097);
  localparam logic [18:0] ERA_DAYS = 19'd146097;

  // Exact reciprocals for narrow dividends: shift = dividend bits + clog2(divisor).
  localparam int unsigned JV_BITS = 21;
  localparam int unsigned J4_SH = JV_BITS + $clog2(1461);
  localparam logic [22:0] J4_RECIP = 23'((64'd1 << J4_SH) / 64'd1461 + 64'd1);

  localparam int unsigned D1460_SH = 18 + $clog2(1460);
  localparam logic [19:0] D1460_RECIP = 20'((64'd1 << D1460_SH) / 64'd1460 + 64'd1);

  localparam int unsigned D365_SH = 18 + $clog2(365);
  localparam logic [19:0] D365_RECIP = 20'((64'd1 << D365_SH) / 64'd365 + 64'd1);

  localparam int unsigned D100_SH = 9 + $clog2(100);
  localparam logic [10:0] D100_RECIP = 11'((64'd1 << D100_SH) / 64'd100 + 64'd1);

  localparam int unsigned D153_SH = 11 + $clog2(153);
  localparam logic [12:0] D153_RECIP = 13'((64'd1 << D153_SH) / 64'd153 + 64'd1);

  // First day of a month within a January-based year, zero based.
  function automatic logic [8:0] month_start(logic [3:0] idx, logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap & (idx >= 4'd2)};
  endfunction

  // First day of a month within a March-based year, zero based.
  function automatic logic [8:0] march_start(logic [3:0] mp);
    logic [8:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

@@ rtl/jdcd_era_div.sv @@
`timescale 1ns / 1ps

// Splits a March-based day count into 400-year eras and the day within the era.
module jdcd_era_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  jdcd_pkg::day_t     z,
  output logic               out_valid,
  output jdcd_pkg::era_t     era,
  output logic [17:0]        doe
);

  logic va;
  logic vb;
  logic vc;
  logic [jdcd_pkg::ZLO_BITS+jdcd_pkg::ERA_BITS-1:0] pp_lo;
  logic [jdcd_pkg::ZHI_BITS+jdcd_pkg::ERA_BITS-1:0] pp_hi;
  logic [18:0] zl_a;
  logic [18:0] zl_b;
  jdcd_pkg::era_prod_t prod_sum;
  jdcd_pkg::era_t q_b;
  jdcd_pkg::era_t q_c;
  logic [jdcd_pkg::ERA_BITS+17:0] qd;
  logic [18:0] rem_c;
  logic [18:0] rem_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  // Partial products of the reciprocal multiply.
  always_ff @(posedge clk) begin
    pp_lo <= {{jdcd_pkg::ERA_BITS{1'b0}}, z[jdcd_pkg::ZLO_BITS-1:0]} *
             {{jdcd_pkg::ZLO_BITS{1'b0}}, jdcd_pkg::ERA_RECIP};
    pp_hi <= {{jdcd_pkg::ERA_BITS{1'b0}}, z[jdcd_pkg::DAY_NUMBER_BITS-1:jdcd_pkg::ZLO_BITS]} *
             {{jdcd_pkg::ZHI_BITS{1'b0}}, jdcd_pkg::ERA_RECIP};
    zl_a  <= z[18:0];
  end

  assign prod_sum = {pp_hi, {jdcd_pkg::ZLO_BITS{1'b0}}} + jdcd_pkg::era_prod_t'(pp_lo);

  always_ff @(posedge clk) begin
    q_b  <= prod_sum[jdcd_pkg::DAY_NUMBER_BITS+jdcd_pkg::ERA_BITS-1:jdcd_pkg::DAY_NUMBER_BITS];
    zl_b <= zl_a;
  end

  // The remainder is below two eras, so its low 19 bits are exact.
  assign qd = {18'd0, q_b} * {{jdcd_pkg::ERA_BITS{1'b0}}, 18'd146097};

  always_ff @(posedge clk) begin
    rem_c <= zl_b - qd[18:0];
    q_c   <= q_b;
  end

  assign rem_adj = rem_c - jdcd_pkg::ERA_DAYS;

  always_ff @(posedge clk) begin
    if (rem_c >= jdcd_pkg::ERA_DAYS) begin
      era <= q_c + jdcd_pkg::era_t'(1);
      doe <= rem_adj[17:0];
    end else begin
      era <= q_c;
      doe <= rem_c[17:0];
    end
  end

endmodule

@@ rtl/julian_day_to_calendar_date_top.sv @@
`timescale 1ns / 1ps
// Julian day number to calendar date converter.
// Each accepted request shows its result with done high for exactly one cycle.
// Throughput: one request per cycle; busy stays low and the result side cannot stall.
// Reset (rst, synchronous, active high) clears all valid bits; no result leaves afterward.

module julian_day_to_calendar_date_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  jdcd_pkg::day_t      day_number,
  output logic                done,
  output logic [4:0]          day_of_month,
  output logic [3:0]          month,
  output jdcd_pkg::year_t     year,
  output logic                before_christ
);

  // Julian calendar result carried alongside the Gregorian stages.
  typedef struct packed {
    logic        bc;
    logic        greg;
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [12:0] year;
  } jul_t;

  // Stage 1: range decode and epoch offsets.
  logic v1;
  logic bc1;
  logic greg1;
  logic [jdcd_pkg::JV_BITS-1:0] jv1;
  logic [jdcd_pkg::JV_BITS-1:0] jv_next;
  jdcd_pkg::day_t z1;
  jdcd_pkg::day_t ad_offset;

  // Stage 2: Julian four-year cycle count.
  logic bc2;
  logic greg2;
  logic [jdcd_pkg::JV_BITS-1:0] jv2;
  logic [10:0] jt2;
  logic [43:0] jprod;

  // Stage 3: day within the four-year cycle.
  logic bc3;
  logic greg3;
  logic [10:0] jt3;
  logic [10:0] jk3;
  logic [20:0] jt_days;
  logic [20:0] jk_full;

  // Stage 4: year within the cycle and day of year.
  logic bc4;
  logic greg4;
  logic leap4;
  logic [8:0] jdoy4;
  logic [12:0] jyear4;
  logic [1:0] yoff;
  logic [10:0] yoff_days;
  logic [10:0] jdoy_full;
  logic leap_next;
  logic [12:0] jyear_next;

  // Stage 5 to 9: Julian result line.
  jul_t jl [5:9];
  logic [3:0] jmon_idx;
  logic [8:0] jdom_full;

  // Gregorian stages, fed by the era divider.
  logic v5;
  jdcd_pkg::era_t era5;
  logic [17:0] doe5;

  logic v6;
  jdcd_pkg::era_t era6;
  logic [17:0] doe6;
  logic [17:0] x6;
  logic [37:0] p1460;
  logic [6:0] q1460;
  logic [2:0] c36524;
  logic c146096;

  logic v7;
  logic [17:0] doe7;
  logic [8:0] yoe7;
  jdcd_pkg::year_t era400_7;
  logic [37:0] p365;
  jdcd_pkg::era400_t era_x400;

  logic v8;
  logic [8:0] doy8;
  jdcd_pkg::year_t gyp8;
  logic [19:0] p100;
  logic [1:0] y100;
  logic [17:0] yday;
  logic [17:0] doy_full;

  logic v9;
  logic [8:0] doy9;
  logic [3:0] mp9;
  jdcd_pkg::year_t gyp9;
  logic [10:0] mnum;
  logic [23:0] p153;

  logic [8:0] gdom_full;
  logic [3:0] gmon;
  jdcd_pkg::year_t gyear;

  // Every stage moves each cycle, so no request is ever held off.
  assign busy = 1'b0;

  // ------------------------------------------------------------------
  // Stage 1. Days before AD 1 count from 4713 BC, which opens a four-year
  // cycle with its leap year. Julian AD days count from 1 January AD 1.
  // The Gregorian path works from a day count that starts on 1 March AD 0.
  // ------------------------------------------------------------------
  assign ad_offset = day_number - jdcd_pkg::AD_EPOCH;
  assign jv_next = (day_number < jdcd_pkg::AD_EPOCH) ? day_number[jdcd_pkg::JV_BITS-1:0]
                                                     : ad_offset[jdcd_pkg::JV_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    bc1   <= day_number < jdcd_pkg::AD_EPOCH;
    greg1 <= day_number > jdcd_pkg::LAST_JULIAN;
    jv1   <= jv_next;
    z1    <= day_number - jdcd_pkg::GREG_MARCH_EPOCH;
  end

  // The 400-year era split takes four stages and lines up with stage 5.
  jdcd_era_div u_era_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .z         (z1),
    .out_valid (v5),
    .era       (era5),
    .doe       (doe5)
  );

  // ------------------------------------------------------------------
  // Stage 2. Number of whole four-year Julian cycles, by an exact
  // reciprocal multiply.
  // ------------------------------------------------------------------
  assign jprod = {23'd0, jv1} * {21'd0, jdcd_pkg::J4_RECIP};

  always_ff @(posedge clk) begin
    bc2   <= bc1;
    greg2 <= greg1;
    jv2   <= jv1;
    jt2   <= jprod[jdcd_pkg::J4_SH+10:jdcd_pkg::J4_SH];
  end

  // ------------------------------------------------------------------
  // Stage 3. Day within the four-year cycle.
  // ------------------------------------------------------------------
  assign jt_days = {10'd0, jt2} * 21'd1461;
  assign jk_full = jv2 - jt_days;

  always_ff @(posedge clk) begin
    bc3   <= bc2;
    greg3 <= greg2;
    jt3   <= jt2;
    jk3   <= jk_full[10:0];
  end

  // ------------------------------------------------------------------
  // Stage 4. A BC cycle opens with its leap year; an AD cycle closes with
  // it. BC years count downward.
  // ------------------------------------------------------------------
  always_comb begin
    if (bc3) begin
      if (jk3 >= 11'd1096) begin
        yoff = 2'd3;
      end else if (jk3 >= 11'd731) begin
        yoff = 2'd2;
      end else if (jk3 >= 11'd366) begin
        yoff = 2'd1;
      end else begin
        yoff = 2'd0;
      end
    end else begin
      if (jk3 >= 11'd1095) begin
        yoff = 2'd3;
      end else if (jk3 >= 11'd730) begin
        yoff = 2'd2;
      end else if (jk3 >= 11'd365) begin
        yoff = 2'd1;
      end else begin
        yoff = 2'd0;
      end
    end
    case (yoff)
      2'd0:    yoff_days = 11'd0;
      2'd1:    yoff_days = 11'd365;
      2'd2:    yoff_days = 11'd730;
      default: yoff_days = 11'd1095;
    endcase
    leap_next = bc3 ? (jk3 < 11'd366) : (jk3 >= 11'd1095);
    // After the leading leap year of a BC cycle every year is one day later.
    jdoy_full = jk3 - yoff_days - {10'd0, bc3 & (jk3 >= 11'd366)};
    jyear_next = bc3 ? (13'd4713 - {jt3, 2'b00} - {11'd0, yoff})
                     : (13'd1 + {jt3, 2'b00} + {11'd0, yoff});
  end

  always_ff @(posedge clk) begin
    bc4    <= bc3;
    greg4  <= greg3;
    leap4  <= leap_next;
    jdoy4  <= jdoy_full[8:0];
    jyear4 <= jyear_next;
  end

  // ------------------------------------------------------------------
  // Stage 5. Month from the count of month starts the day has passed.
  // ------------------------------------------------------------------
  always_comb begin
    jmon_idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (jdoy4 >= jdcd_pkg::month_start(4'(i), leap4)) begin
        jmon_idx = jmon_idx + 4'd1;
      end
    end
    jdom_full = jdoy4 - jdcd_pkg::month_start(jmon_idx, leap4) + 9'd1;
  end

  always_ff @(posedge clk) begin
    jl[5].bc   <= bc4;
    jl[5].greg <= greg4;
    jl[5].dom  <= jdom_full[4:0];
    jl[5].mon  <= jmon_idx + 4'd1;
    jl[5].year <= jyear4;
    for (int i = 6; i <= 9; i++) begin
      jl[i] <= jl[i-1];
    end
  end

  // ------------------------------------------------------------------
  // Stage 6. Gregorian year-of-era numerator: remove one day per four
  // years, add back one per century and take off the last day of the era.
  // ------------------------------------------------------------------
  assign p1460 = {20'd0, doe5} * {18'd0, jdcd_pkg::D1460_RECIP};
  assign q1460 = p1460[jdcd_pkg::D1460_SH+6:jdcd_pkg::D1460_SH];
  assign c36524 = {2'd0, doe5 >= 18'd36524} + {2'd0, doe5 >= 18'd73048} +
                  {2'd0, doe5 >= 18'd109572} + {2'd0, doe5 >= 18'd146096};
  assign c146096 = (doe5 == 18'd146096);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    era6 <= era5;
    doe6 <= doe5;
    x6   <= doe5 - {11'd0, q1460} + {15'd0, c36524} - {17'd0, c146096};
  end

  // ------------------------------------------------------------------
  // Stage 7. Year of era, and the era's first year.
  // ------------------------------------------------------------------
  assign p365 = {20'd0, x6} * {18'd0, jdcd_pkg::D365_RECIP};
  assign era_x400 = {9'd0, era6} * jdcd_pkg::era400_t'(400);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    doe7      <= doe6;
    yoe7      <= p365[jdcd_pkg::D365_SH+8:jdcd_pkg::D365_SH];
    era400_7  <= jdcd_pkg::year_t'(era_x400);
  end

  // ------------------------------------------------------------------
  // Stage 8. Day of the March-based year.
  // ------------------------------------------------------------------
  assign p100 = {11'd0, yoe7} * {9'd0, jdcd_pkg::D100_RECIP};
  assign y100 = p100[jdcd_pkg::D100_SH+1:jdcd_pkg::D100_SH];
  assign yday = {9'd0, yoe7} * 18'd365 + {11'd0, yoe7[8:2]} - {16'd0, y100};
  assign doy_full = doe7 - yday;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    doy8 <= doy_full[8:0];
    gyp8 <= era400_7 + jdcd_pkg::year_t'(yoe7);
  end

  // ------------------------------------------------------------------
  // Stage 9. Month of the March-based year.
  // ------------------------------------------------------------------
  assign mnum = {2'd0, doy8} * 11'd5 + 11'd2;
  assign p153 = {13'd0, mnum} * {11'd0, jdcd_pkg::D153_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    doy9 <= doy8;
    mp9  <= p153[jdcd_pkg::D153_SH+3:jdcd_pkg::D153_SH];
    gyp9 <= gyp8;
  end

  // ------------------------------------------------------------------
  // Stage 10. Gregorian day and month; January and February belong to the
  // next calendar year. The output register picks the calendar in force.
  // ------------------------------------------------------------------
  assign gdom_full = doy9 - jdcd_pkg::march_start(mp9) + 9'd1;
  assign gmon = (mp9 < 4'd10) ? (mp9 + 4'd3) : (mp9 - 4'd9);
  assign gyear = gyp9 + jdcd_pkg::year_t'(gmon <= 4'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (jl[9].greg) begin
      day_of_month  <= gdom_full[4:0];
      month         <= gmon;
      year          <= gyear;
      before_christ <= 1'b0;
    end else begin
      day_of_month  <= jl[9].dom;
      month         <= jl[9].mon;
      year          <= jdcd_pkg::year_t'(jl[9].year);
      before_christ <= jl[9].bc;
    end
  end

endmodule

@@ rtl/jdcd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jdcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [3:0]          month,
  input jdcd_pkg::year_t     year,
  input logic                before_christ
);

  // Every accepted request produces its result after a fixed delay.
  `ASSERT_DELAY(a_req_to_done, clk, rst, start && !busy, jdcd_pkg::LATENCY, done)

  // No result appears without a request accepted the same delay earlier.
  `ASSERT_IMPLY(a_done_has_req, clk, rst, done, $past(start && !busy, jdcd_pkg::LATENCY))

  `ASSERT_IMPLY(a_month_range, clk, rst, done, month >= 4'd1 && month <= 4'd12)

  // BC years run from 4713 down to 1.
  `ASSERT_IMPLY(a_bc_year, clk, rst, done && before_christ,
                year >= jdcd_pkg::year_t'(1) && year <= jdcd_pkg::year_t'(4713))

endmodule

bind julian_day_to_calendar_date_top jdcd_checker u_jdcd_checker (.*);

@@ verif/calendar_date_checker.sv @@
`timescale 1ns / 1ps

module calendar_date_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  jdcd_pkg::day_t      day_number,
  input  logic                done,
  input  logic [4:0]          day_of_month,
  input  logic [3:0]          month,
  input  jdcd_pkg::year_t     year,
  input  logic                before_christ,
  output int unsigned         fails,
  output int unsigned         outstanding
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [4:0]      dom;
    logic [3:0]      mon;
    jdcd_pkg::year_t yr;
    logic            bc;
  } cal_date_t;

  typedef struct packed {
    jdcd_pkg::day_t dn;
    cal_date_t      want;
  } date_due_t;

  date_due_t   dates_due[$];
  int unsigned fail_cnt = 0;
  int unsigned due_cnt = 0;

  assign fails = fail_cnt;
  assign outstanding = due_cnt;

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Walks the months of a January-based year until the zero-based day fits.
  function automatic void place_in_year(input longint unsigned doy, input bit leap,
                                        output logic [4:0] dom, output logic [3:0] mon);
    longint unsigned rest;
    int unsigned     m;
    rest = doy;
    m = 1;
    while (m < 12 && rest >= month_days(m, leap)) begin
      rest -= month_days(m, leap);
      m++;
    end
    dom = 5'(rest + 1);
    mon = 4'(m);
  endfunction

  function automatic cal_date_t calendar_of_day(jdcd_pkg::day_t dn);
    cal_date_t       d;
    longint unsigned r, cyc, k, z, era, doe, yoe, doy, mp, mon_g, y;
    r = dn;
    d.bc = 1'b0;
    if (r < 64'd1721424) begin
      // Each BC period of 1461 days opens with a leap year, such as 4713 BC and 4709 BC.
      cyc = r / 1461;
      k = r % 1461;
      y = 4713 - 4 * cyc;
      d.bc = 1'b1;
      if (k < 366) begin
        place_in_year(k, 1'b1, d.dom, d.mon);
      end else begin
        y = y - 1 - (k - 366) / 365;
        place_in_year((k - 366) % 365, 1'b0, d.dom, d.mon);
      end
    end else if (r <= 64'd2299160) begin
      // AD Julian cycles: three common years, then a leap year.
      cyc = (r - 1721424) / 1461;
      k = (r - 1721424) % 1461;
      y = 1 + 4 * cyc;
      if (k < 1095) begin
        y += k / 365;
        place_in_year(k % 365, 1'b0, d.dom, d.mon);
      end else begin
        y += 3;
        place_in_year(k - 1095, 1'b1, d.dom, d.mon);
      end
    end else begin
      // Gregorian, counted in 400-year eras of years that begin on 1 March.
      z = r - 1721120;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      d.dom = 5'(doy - (153 * mp + 2) / 5 + 1);
      mon_g = (mp < 10) ? mp + 3 : mp - 9;
      d.mon = 4'(mon_g);
      y = yoe + era * 400 + ((mon_g <= 2) ? 1 : 0);
    end
    d.yr = jdcd_pkg::year_t'(y);
    return d;
  endfunction

  always @(posedge clk) begin
    date_due_t head;
    cal_date_t got;
    if (rst) begin
      dates_due.delete();
    end else begin
      if (done) begin
        got = '{dom: day_of_month, mon: month, yr: year, bc: before_christ};
        if (dates_due.size() == 0) begin
          if (fail_cnt < REPORT_LIMIT) begin
            $display("unexpected result %0d/%0d/%0d bc=%0b with no request waiting",
                     got.dom, got.mon, got.yr, got.bc);
          end
          fail_cnt <= fail_cnt + 1;
        end else begin
          head = dates_due.pop_front();
          if (got != head.want) begin
            if (fail_cnt < REPORT_LIMIT) begin
              $display("day %0d: expected %0d/%0d/%0d bc=%0b, got %0d/%0d/%0d bc=%0b",
                       head.dn, head.want.dom, head.want.mon, head.want.yr, head.want.bc,
                       got.dom, got.mon, got.yr, got.bc);
            end
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (start && !busy) begin
        dates_due.push_back('{dn: day_number, want: calendar_of_day(day_number)});
      end
    end
    due_cnt <= dates_due.size();
  end

endmodule

@@ verif/julian_day_to_calendar_date_top_tb.sv @@
`timescale 1ns / 1ps

module julian_day_to_calendar_date_top_tb;

  localparam int unsigned DIRECTED_REQUESTS = 25;
  localparam int unsigned RANDOM_REQUESTS = 1050;
  localparam int unsigned MAX_GAP = 14;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  jdcd_pkg::day_t  day_number = '0;
  logic            busy;
  logic            done;
  logic [4:0]      day_of_month;
  logic [3:0]      month;
  jdcd_pkg::year_t year;
  logic            before_christ;
  int unsigned     fails;
  int unsigned     outstanding;

  always #6 clk = ~clk;

  julian_day_to_calendar_date_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .day_number    (day_number),
    .done          (done),
    .day_of_month  (day_of_month),
    .month         (month),
    .year          (year),
    .before_christ (before_christ)
  );

  // The checker watches both sides of the block, predicts each date and
  // compares; it reports how many checks failed and how many requests are
  // still waiting for their result.
  calendar_date_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .day_number    (day_number),
    .done          (done),
    .day_of_month  (day_of_month),
    .month         (month),
    .year          (year),
    .before_christ (before_christ),
    .fails         (fails),
    .outstanding   (outstanding)
  );

  // The slowest correct run is about 1100 requests, each followed by the longest gap,
  // roughly 0.2 ms; this limit leaves a wide margin on top of that.
  initial begin
    #5_000_000;
    $display("julian_day_to_calendar_date_top_tb NOT OK");
    $finish;
  end

  // Presents one request and holds it until the block takes it. After that
  // start either stays high for the next request (no gap) or drops for the
  // drawn number of idle cycles, with junk on the day number meanwhile so
  // that the block is seen to ignore it.
  task automatic issue(jdcd_pkg::day_t dn, int unsigned gap);
    start <= 1'b1;
    day_number <= dn;
    do begin
      @(posedge clk);
    end while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      day_number <= jdcd_pkg::day_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending until every request in flight has produced its result.
  // The checker's count is registered, so the task lets it update at the next edge before reading it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // Hand-picked day numbers: the ends of the input range, leap days and
  // year ends on both sides of the era boundary, the switch from the Julian
  // to the Gregorian calendar, century years and alternating bit patterns.
  function automatic jdcd_pkg::day_t directed_day(int unsigned idx);
    case (idx)
      0:       return 39'd0;                  // 1 January 4713 BC
      1:       return 39'd59;                 // 29 February 4713 BC
      2:       return 39'd365;                // 31 December 4713 BC
      3:       return 39'd366;                // 1 January 4712 BC
      4:       return 39'd1460;               // last day of the first BC cycle
      5:       return 39'd1461;
      6:       return 39'd1721058;            // 1 January 1 BC, a leap year
      7:       return 39'd1721117;            // 29 February 1 BC
      8:       return 39'd1721423;            // 31 December 1 BC
      9:       return 39'd1721424;            // 1 January AD 1
      10:      return 39'd2818;               // inside a common BC year
      11:      return 39'd1722518;            // 31 December AD 3
      12:      return 39'd1722519;            // 1 January AD 4, a leap year
      13:      return 39'd1722578;            // 29 February AD 4
      14:      return 39'd2299151;            // still Julian
      15:      return 39'd2299160;            // 4 October 1582, last Julian day
      16:      return 39'd2299161;            // 15 October 1582, first Gregorian day
      17:      return 39'd2415079;            // 28 February 1900, not a leap year
      18:      return 39'd2415080;            // 1 March 1900
      19:      return 39'd2451604;            // 29 February 2000
      20:      return 39'd4294967295;
      21:      return 39'h55_5555_5555;
      22:      return 39'h2A_AAAA_AAAA;
      23:      return 39'h7F_FFFF_FFFE;
      default: return 39'h7F_FFFF_FFFF;        // largest day number
    endcase
  endfunction

  // Random day numbers, weighted toward the regions where the arithmetic
  // changes: the BC and AD Julian ranges, the calendar switch, the common
  // Gregorian range, 400-year era edges, powers of two and the full width.
  function automatic jdcd_pkg::day_t random_day();
    int unsigned     pick;
    int unsigned     k;
    longint unsigned v;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      v = (longint'($urandom_range(0, 127)) << 32) | longint'($urandom);
    end else if (pick <= 4) begin
      v = $urandom_range(0, 1721423);
    end else if (pick == 5) begin
      v = $urandom_range(1721424, 2299160);
    end else if (pick == 6) begin
      v = $urandom_range(2299130, 2299190);
    end else if (pick == 7) begin
      v = $urandom_range(2299161, 5373484);
    end else if (pick == 8) begin
      v = 64'd1721120 + 64'd146097 * $urandom_range(1, 3_700_000) + $urandom_range(0, 800);
      v = v - 400;
    end else begin
      k = $urandom_range(0, 38);
      v = (64'd1 << k) - $urandom_range(0, 1);
    end
    return jdcd_pkg::day_t'(v);
  endfunction

  initial begin
    bit burst;
    burst = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned i = 0; i < DIRECTED_REQUESTS; i++) begin
      issue(directed_day(i), $urandom_range(0, MAX_GAP));
    end
    // Let the pipeline run completely dry once before the random part.
    drain();

    // Random requests. Every 64 requests a new draw decides whether the
    // next stretch is sent back to back or with random gaps.
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 64 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_REQUESTS / 2) begin
        drain();
      end
      issue(random_day(), burst ? 0 : $urandom_range(0, MAX_GAP));
    end

    drain();
    // Waiting on after the drain catches any stray result after the last expected one.
    repeat (jdcd_pkg::LATENCY + 5) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("julian_day_to_calendar_date_top_tb OK");
    end else begin
      $display("julian_day_to_calendar_date_top_tb NOT OK");
    end
    $finish;
  end

endmodule
